// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by syscall_trace_filter_table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked implication, next-cycle form, ignored while reset is high.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/stft_pkg.sv -----
// ---------------------------------------------------------------------------
// stft_pkg
// Types and constants of the trace filter table.
// ---------------------------------------------------------------------------
package stft_pkg;

  // Default number of table slots
  localparam int ENTRIES_DEF = 16;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int CODE_W   = 8;
  localparam int TOTAL_W  = 5;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;
  localparam logic [1:0] REG_END    = 2'd3;

  // Request word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CODE_W-1:0]   call_code;
  } req_word_t;

  // Response word
  typedef struct packed {
    logic               status;
    logic               record_call;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_word_t;

endpackage

// ----- hdl/syscall_trace_filter_table.sv -----
// ---------------------------------------------------------------------------
// syscall_trace_filter_table
// Set of call codes that selects which calls are traced, with add, remove,
// clear and check actions.
// ---------------------------------------------------------------------------
// Takes one request word per cycle and returns one response word for each.
// The request lands in an input register, then one pass of parallel
// compares against all slots resolves the action and loads the response
// register while the table updates at the same edge, so the following
// request already sees the new set. The request side stalls only while a
// response is waiting and the response register is still full. Add takes
// the lowest free slot. No clearing pass is needed after reset.
`include "assert_macros.svh"

module syscall_trace_filter_table
  import stft_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  req_word_t         req,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_word_t         rsp,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Configuration registers
  logic              trace_enabled;
  logic              trace_mode;
  logic [CODE_W-1:0] start_code;
  logic [CODE_W-1:0] end_code;

  // Table state
  logic [CODE_W-1:0]  entry_code [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]   entry_count;

  // Input stage
  logic      stage_valid;
  req_word_t stage;

  // Pass logic
  logic               advance;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] free_slot;
  logic [ENTRIES-1:0] add_slot;
  logic               present;
  logic               full;
  logic [ENTRIES-1:0] entry_valid_next;
  logic [CNT_W-1:0]   entry_count_next;
  logic               do_write;
  rsp_word_t          rsp_next;

  // Register write/read
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enabled <= 1'b0;
      trace_mode    <= 1'b0;
      start_code    <= '0;
      end_code      <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_ENABLE: trace_enabled <= pwdata[0];
        REG_MODE:   trace_mode    <= pwdata[0];
        REG_START:  start_code    <= pwdata[CODE_W-1:0];
        REG_END:    end_code      <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_ENABLE: prdata = DATA_W'(trace_enabled);
      REG_MODE:   prdata = DATA_W'(trace_mode);
      REG_START:  prdata = DATA_W'(start_code);
      REG_END:    prdata = DATA_W'(end_code);
      default:    prdata = '0;
    endcase
  end

  // Handshake: stage moves on whenever the response register is empty or being read
  assign advance   = ~rsp_valid | rsp_ready;
  assign req_ready = ~stage_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage <= req;
    end
  end

  // Parallel compare of the staged code against every slot
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit[i] = entry_valid[i] && (entry_code[i] == stage.call_code);
    end
  end

  assign present   = |hit;
  assign full      = (entry_count >= CNT_W'(ENTRIES));
  assign free_slot = ~entry_valid;
  assign add_slot  = free_slot & (~free_slot + ENTRIES'(1));  // lowest free

  // Action decode
  always_comb begin
    entry_valid_next     = entry_valid;
    entry_count_next     = entry_count;
    do_write             = 1'b0;
    rsp_next.status      = 1'b0;
    rsp_next.record_call = 1'b0;
    case (stage.action)
      ACT_ADD: begin
        if (full || present) begin
          rsp_next.status = 1'b1;
        end else begin
          entry_valid_next = entry_valid | add_slot;
          entry_count_next = entry_count + CNT_W'(1);
          do_write         = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!present) begin
          rsp_next.status = 1'b1;
        end else begin
          entry_valid_next = entry_valid & ~hit;
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      ACT_CHECK: begin
        rsp_next.record_call = trace_enabled
                            && (stage.call_code != start_code)
                            && (stage.call_code != end_code)
                            && (!trace_mode || present);
      end
      default: begin
        entry_valid_next = '0;
        entry_count_next = '0;
      end
    endcase
    rsp_next.entry_total = TOTAL_W'(entry_count_next);
  end

  // Table update, at the same edge that loads the response
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
    end else if (stage_valid && advance) begin
      entry_valid <= entry_valid_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (stage_valid && advance && do_write && add_slot[i]) begin
        entry_code[i] <= stage.call_code;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && advance) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  `ASSERT_CLK(a_count_matches, (32'(entry_count) == $countones(entry_valid)), "count out of step with valid bits")
  `ASSERT_CLK(a_count_bound, (entry_count <= CNT_W'(ENTRIES)), "count above table size")
  `ASSERT_NEXT(a_reject_keeps_set, (stage_valid && advance && stage.action == ACT_ADD && rsp_next.status), $stable(entry_valid), "rejected add changed the set")
  `ASSERT_NEXT(a_stage_to_rsp, (stage_valid && advance), rsp_valid, "staged word produced no response")

endmodule
